>>> design/b64enc_pkg.sv
// b64enc_pkg: shared types, constants and the character mapping of the base64 stream encoder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package b64enc_pkg;

  // input transaction payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  // output transaction payload
  typedef struct packed {
    logic [6:0] text_char;
    logic       last_char;
  } out_t;

  // one closed group handed from the front to the back
  typedef struct packed {
    logic [23:0] bytes;   // first byte in the top bits, zero filled
    logic [1:0]  used;    // bytes that carry data, 1 to 3
    logic        last;    // group closes the message
  } grp_t;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [6:0] PadChar   = 7'd61;  // '='
  localparam logic [6:0] UpperBase = 7'd65;  // 'A'
  localparam logic [6:0] LowerBase = 7'd97;  // 'a'
  localparam logic [6:0] DigitBase = 7'd48;  // '0'
  localparam logic [6:0] PlusChar  = 7'd43;  // '+'
  localparam logic [6:0] SlashChar = 7'd47;  // '/'

  // map a 6-bit value onto the standard alphabet
  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] v7;
    v7 = {1'b0, v};
    if (v < 6'd26) begin
      b64_char = UpperBase + v7;
    end else if (v < 6'd52) begin
      b64_char = LowerBase + v7 - 7'd26;
    end else if (v < 6'd62) begin
      b64_char = DigitBase + v7 - 7'd52;
    end else if (v == 6'd62) begin
      b64_char = PlusChar;
    end else begin
      b64_char = SlashChar;
    end
  endfunction

endpackage

`default_nettype wire

>>> design/b64enc_front.sv
// b64enc_front: takes input bytes, holds up to two pending bytes, closes groups
// depends on b64enc_pkg; feeds b64enc_queue
`timescale 1ns / 1ps
`default_nettype none

module b64enc_front
  import b64enc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_i,
  output logic      push_o,
  output grp_t      push_grp_o,
  input  wire logic q_full_i
);

  logic [1:0] cnt_q, cnt_d;
  logic [7:0] p0_q, p0_d, p1_q, p1_d;
  logic       acc;

  // accept only when a closing byte can be queued
  assign in_ready_o = !q_full_i;
  assign acc        = in_valid_i && in_ready_o;

  // group assembly
  always_comb begin
    cnt_d      = cnt_q;
    p0_d       = p0_q;
    p1_d       = p1_q;
    push_o     = 1'b0;
    push_grp_o = '{bytes: {p0_q, p1_q, in_i.data_byte}, used: 2'd3, last: in_i.last_byte};
    if (acc) begin
      priority if (cnt_q == 2'd2) begin
        push_o = 1'b1;
        cnt_d  = 2'd0;
      end else if (in_i.last_byte) begin
        push_o = 1'b1;
        cnt_d  = 2'd0;
        if (cnt_q == 2'd0) begin
          push_grp_o = '{bytes: {in_i.data_byte, 16'h0000}, used: 2'd1, last: 1'b1};
        end else begin
          push_grp_o = '{bytes: {p0_q, in_i.data_byte, 8'h00}, used: 2'd2, last: 1'b1};
        end
      end else begin
        if (cnt_q == 2'd0) begin
          p0_d = in_i.data_byte;
        end else begin
          p1_d = in_i.data_byte;
        end
        cnt_d = cnt_q + 2'd1;
      end
    end
  end

  // pending count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // pending bytes
  always_ff @(posedge clk_i) begin
    p0_q <= p0_d;
    p1_q <= p1_d;
  end

endmodule

`default_nettype wire

>>> design/b64enc_queue.sv
// b64enc_queue: short group queue between front and back
// depends on b64enc_pkg
`timescale 1ns / 1ps
`default_nettype none

module b64enc_queue
  import b64enc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire grp_t push_grp_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output grp_t      head_o
);

  grp_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_grp_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/b64enc_back.sv
// b64enc_back: turns each queued group into four characters, one per cycle while the output is not stalled
// depends on b64enc_pkg; reads from b64enc_queue
`timescale 1ns / 1ps
`default_nettype none

module b64enc_back
  import b64enc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_valid_i,
  input  wire grp_t q_head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_o
);

  grp_t       grp_q;
  logic       grp_vld_q;
  logic [1:0] idx_q;
  logic       out_vld_q;
  out_t       out_q;
  logic       load_out;
  logic       grp_done;
  logic [5:0] six;
  out_t       chr;

  assign load_out = !out_vld_q || out_ready_i;
  assign grp_done = load_out && grp_vld_q && (idx_q == 2'd3);
  assign pop_o    = q_valid_i && (!grp_vld_q || grp_done);

  // pick the 6-bit field of the current character
  always_comb begin
    unique case (idx_q)
      2'd0:    six = grp_q.bytes[23:18];
      2'd1:    six = grp_q.bytes[17:12];
      2'd2:    six = grp_q.bytes[11:6];
      default: six = grp_q.bytes[5:0];
    endcase
    chr.text_char = (idx_q <= grp_q.used) ? b64_char(six) : PadChar;
    chr.last_char = (idx_q == 2'd3) && grp_q.last;
  end

  // group holder and character index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_vld_q <= 1'b0;
      idx_q     <= 2'd0;
      out_vld_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_vld_q <= grp_vld_q;
      end
      if (load_out && grp_vld_q) begin
        idx_q <= idx_q + 2'd1;
      end
      if (pop_o) begin
        grp_vld_q <= 1'b1;
      end else if (grp_done) begin
        grp_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      grp_q <= q_head_i;
    end
    if (load_out && grp_vld_q) begin
      out_q <= chr;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

>>> design/base64_stream_encoder_top.sv
// base64_stream_encoder_top: base64 encoder, bytes in, padded ascii text out
// depends on b64enc_pkg, b64enc_front, b64enc_queue, b64enc_back
//
//   channel | signals                         | payload
//   --------+---------------------------------+---------------------------
//   input   | in_valid_i / in_ready_o / in_i  | data_byte[7:0], last_byte
//   output  | out_valid_o / out_ready_i / out_o | text_char[6:0], last_char
//
// a byte is taken in the cycle it arrives whenever the group queue has room;
// every closed group leaves as four characters, sent back to back while the output is not stalled,
// so the output port sets the rate: four characters per three bytes, and four per short final group.
// the closing byte's group passes the queue, the group holder and the output register.
// reset clears pending count, queue and output valid; no clearing pass.
// a stalled output holds its character while the front keeps taking bytes until the queue fills.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_encoder_top
  import b64enc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_o
);

  logic push, q_full, pop, q_valid;
  grp_t push_grp, q_head;

  // byte intake and grouping
  b64enc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .push_o     (push),
    .push_grp_o (push_grp),
    .q_full_i   (q_full)
  );

  // group queue
  b64enc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_grp_i (push_grp),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  // character emission
  b64enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

>>> dv/testbench.sv
// testbench: self-checking bench for base64_stream_encoder_top, directed and random messages
// predicts the padded base64 text per byte; depends on b64enc_pkg and the encoder rtl
`timescale 1ns / 1ps

module testbench;
  import b64enc_pkg::*;

  localparam int unsigned HoldCycles = 200;   // long receiver hold-off for the fill test
  localparam int unsigned QuietLimit = 2000;  // cycles with no transaction before giving up

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_o;

  // idling controls for sender and receiver, and the error count
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned error_count = 0;

  // predictor state: bytes held for the current group
  logic [1:0] held_count;
  logic [7:0] held_bytes [2];
  out_t       expected_text [$];
  string      b64_alphabet = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ", "abcdefghijklmnopqrstuvwxyz",
                              "0123456789+/"};

  base64_stream_encoder_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  always #4 clk_i = ~clk_i;

  // four characters of one group, pad after used+1 data characters
  function automatic void queue_group(input logic [7:0] b0, input logic [7:0] b1,
                                      input logic [7:0] b2, input int unsigned used,
                                      input logic last);
    logic [5:0] sextet [4];
    out_t       ch;
    byte        code;
    sextet[0] = b0[7:2];
    sextet[1] = {b0[1:0], b1[7:4]};
    sextet[2] = {b1[3:0], b2[7:6]};
    sextet[3] = b2[5:0];
    for (int k = 0; k < 4; k++) begin
      if (k <= used) begin
        code = b64_alphabet[sextet[k]];
        ch.text_char = code[6:0];
      end else begin
        ch.text_char = PadChar;
      end
      ch.last_char = (k == 3) ? last : 1'b0;
      expected_text.push_back(ch);
    end
  endfunction

  // advance the encoder state by one accepted byte
  function automatic void encode_byte(input in_t item);
    if (held_count == 2'd2) begin
      queue_group(held_bytes[0], held_bytes[1], item.data_byte, 3, item.last_byte);
      held_count = 2'd0;
    end else if (item.last_byte) begin
      if (held_count == 2'd0) begin
        queue_group(item.data_byte, 8'h00, 8'h00, 1, 1'b1);
      end else begin
        queue_group(held_bytes[0], item.data_byte, 8'h00, 2, 1'b1);
      end
      held_count = 2'd0;
    end else begin
      held_bytes[held_count] = item.data_byte;
      held_count = held_count + 2'd1;
      return;
    end
    held_bytes[0] = 8'h00;
    held_bytes[1] = 8'h00;
  endfunction

  // send one byte; valid stays high if the next transaction follows at once
  task automatic send_byte(input logic [7:0] data, input logic last);
    in_t item;
    item.data_byte = data;
    item.last_byte = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    encode_byte(item);
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(255)), (i == len - 1));
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    static int unsigned hold_seen = 0;
    static int unsigned hold_left = 0;
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compare each output transaction with the oldest expected character
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual char %0d last %b",
                 $time, out_o.text_char, out_o.last_char);
        error_count++;
      end else begin
        want = expected_text.pop_front();
        if (out_o.text_char !== want.text_char) begin
          $display("%0t: text_char mismatch: expected %0d, actual %0d",
                   $time, want.text_char, out_o.text_char);
          error_count++;
        end
        if (out_o.last_char !== want.last_char) begin
          $display("%0t: last_char mismatch: expected %b, actual %b",
                   $time, want.last_char, out_o.last_char);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    static int unsigned quiet = 0;
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
      if (quiet >= QuietLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // extremes, every group closing case and both ends of the alphabet
  task automatic test_directed();
    send_byte(8'h00, 1'b1);                          // one byte: two chars and "=="
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0); send_byte(8'hff, 1'b1);  // two bytes: three chars and "="
    send_byte(8'hff, 1'b0); send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b1);  // "AAAA"
    send_byte(8'hff, 1'b0); send_byte(8'hff, 1'b0); send_byte(8'hff, 1'b1);  // "////"
    send_byte(8'hfb, 1'b0); send_byte(8'hef, 1'b0); send_byte(8'hbe, 1'b1);  // "++++"
    send_byte(8'h4d, 1'b0); send_byte(8'h61, 1'b0); send_byte(8'h6e, 1'b0);  // full group, more
    send_byte(8'h03, 1'b0); send_byte(8'hd9, 1'b1);
    send_byte(8'hd3, 1'b0); send_byte(8'h5d, 1'b0); send_byte(8'hb7, 1'b0);
    send_byte(8'h80, 1'b1);
  endtask

  // random messages, mostly short, some long
  task automatic test_random_messages(input int unsigned budget, input int unsigned idle_pct,
                                      input int unsigned stall_pct);
    int unsigned sent;
    int unsigned len;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(30, 10) : $urandom_range(9, 1);
      send_message(len);
      sent += len;
    end
  endtask

  // receiver held off long while the sender keeps offering bytes
  task automatic test_output_hold();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests++;
    send_message(24);
    send_message(5);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_i        = '0;
    out_ready_i = 1'b0;
    held_count  = 2'd0;
    held_bytes[0] = 8'h00;
    held_bytes[1] = 8'h00;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_messages(70, 0, 0);
    test_random_messages(70, 57, 0);
    test_random_messages(70, 0, 57);
    test_output_hold();
    test_random_messages(70, 23, 23);

    // drain the remaining characters
    in_valid_i <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (expected_text.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/b64enc_pkg.sv
design/b64enc_front.sv
design/b64enc_queue.sv
design/b64enc_back.sv
design/base64_stream_encoder_top.sv
dv/testbench.sv
